### rtl/ehm_pkg.sv
`default_nettype none
package ehm_pkg;

  localparam int unsigned NumRampRegs = 6;
  localparam int unsigned RegW        = 48;
  localparam int unsigned ElevW       = 18;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned PointW      = 42;
  localparam int unsigned LevelW      = 48;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned NumW        = 28;
  localparam int unsigned DenW        = 20;

  localparam logic [IdxW-1:0] IdxFlood = 3'd6;

  localparam logic signed [ElevW-1:0] InvalidElev = -18'sd40;
  localparam logic [ChanW:0]          TintAdd     = 9'd90;
  localparam logic [ChanW:0]          ChanLimit   = 9'd255;

  localparam logic [PointW-1:0] RampReset [NumRampRegs] = '{
    42'd4397991762478, 42'd24042606, 42'd1352071910,
    42'd5043707080, 42'd6725353130, 42'd13438203020
  };
  localparam logic [LevelW-1:0] LevelReset = 48'd429500006410;

  // One ramp channel ready for division
  typedef struct packed {
    logic                   direct;
    logic [ChanW-1:0]       color;
    logic signed [NumW-1:0] num;
  } chan_job_t;

  // Per-pixel division job for three channels
  typedef struct packed {
    logic [DenW-1:0] den;
    chan_job_t [2:0] chan;
  } div_job_t;

endpackage
`default_nettype wire

### rtl/ehm_divider.sv
`default_nettype none
// Pipelined floor division: one quotient bit per stage, clamped to 0..255.
module ehm_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  ehm_pkg::div_job_t            job_i,
  output logic                         valid_o,
  output logic [3*ehm_pkg::ChanW-1:0]  color_o
);
  import ehm_pkg::*;

  // Quotient of up to 10 bits, larger ones saturate: 10 stages
  localparam int unsigned QW = 10;
  localparam int unsigned RW = DenW + 1;

  logic            v_q   [QW+1];
  logic [DenW-1:0] den_q [QW+1];
  logic [2:0]      neg_q [QW+1];
  logic [2:0]      big_q [QW+1];
  logic [2:0]      dir_q [QW+1];
  logic [ChanW-1:0] col_q [QW+1][3];
  logic [NumW-1:0]  rem_q [QW+1][3];
  logic [QW-1:0]    quo_q [QW+1][3];

  // Stage 0: take magnitudes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q[0] <= job_i.den;
    for (int c = 0; c < 3; c++) begin
      neg_q[0][c] <= job_i.chan[c].num[NumW-1];
      dir_q[0][c] <= job_i.chan[c].direct;
      col_q[0][c] <= job_i.chan[c].color;
      rem_q[0][c] <= job_i.chan[c].num[NumW-1] ? NumW'(-job_i.chan[c].num)
                                               : NumW'(job_i.chan[c].num);
      quo_q[0][c] <= '0;
      big_q[0][c] <= 1'b0;
    end
  end

  // Restoring division stages, MSB first
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned Sh = QW - 1 - s;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      logic [NumW+QW-1:0] trial;
      logic [NumW-1:0]    hi;
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      dir_q[s+1] <= dir_q[s];
      for (int c = 0; c < 3; c++) begin
        trial = (NumW+QW)'(den_q[s]) << Sh;
        col_q[s+1][c] <= col_q[s][c];
        // quotient too big for QW bits: saturate
        hi = (s == 0) ? (rem_q[s][c] >> (QW)) : '0;
        if (s == 0 && hi >= NumW'(den_q[s])) begin
          big_q[s+1][c] <= 1'b1;
        end else begin
          big_q[s+1][c] <= big_q[s][c];
        end
        if ((NumW+QW)'(rem_q[s][c]) >= trial) begin
          rem_q[s+1][c] <= NumW'((NumW+QW)'(rem_q[s][c]) - trial);
          quo_q[s+1][c] <= quo_q[s][c] | (QW'(1) << Sh);
        end else begin
          rem_q[s+1][c] <= rem_q[s][c];
          quo_q[s+1][c] <= quo_q[s][c];
        end
      end
    end
  end

  // Output stage: direct colors pass, negatives give 0, big quotients 255
  logic [ChanW-1:0] out_q [3];
  logic             vout_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else begin
      vout_q <= v_q[QW];
    end
  end
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (dir_q[QW][c]) begin
        out_q[c] <= col_q[QW][c];
      end else if (neg_q[QW][c]) begin
        out_q[c] <= '0;
      end else if (big_q[QW][c] || quo_q[QW][c] > QW'(255)) begin
        out_q[c] <= 8'hFF;
      end else begin
        out_q[c] <= quo_q[QW][c][ChanW-1:0];
      end
    end
  end

  assign valid_o = vout_q;
  assign color_o = {out_q[0], out_q[1], out_q[2]};
endmodule
`default_nettype wire

### rtl/ehm_front.sv
`default_nettype none
// Segment select, numerator products and flood tint, two register stages.
module ehm_front #(
  parameter int unsigned RampPoints = 6
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  logic signed [ehm_pkg::ElevW-1:0]         elev_i,
  input  logic [ehm_pkg::PointW-1:0]               point_i [ehm_pkg::NumRampRegs],
  input  logic [ehm_pkg::LevelW-1:0]               levels_i,
  input  logic [3*ehm_pkg::ChanW-1:0]              pixel_i,
  output logic                                     valid_o,
  output ehm_pkg::div_job_t                        job_o,
  output logic [3*ehm_pkg::ChanW-1:0]              tint_o
);
  import ehm_pkg::*;

  localparam int unsigned Last = RampPoints - 1;

  function automatic logic signed [ElevW-1:0] pelev(input logic [PointW-1:0] p);
    return signed'(p[41:24]);
  endfunction

  // Stage A: choose segment, tint
  logic                    va_q;
  logic signed [ElevW-1:0] e_q, e0_q, e1_q;
  logic [ChanW-1:0]        c0_q [3], c1_q [3];
  logic                    dir_q;
  logic [3*ChanW-1:0]      tint_q;
  logic [3*ChanW-1:0]      tint_d;

  always_comb begin
    logic [ChanW-1:0] px [3];
    logic signed [ElevW+2:0] l [3];
    logic t [3];
    logic [ChanW:0] sum;
    for (int c = 0; c < 3; c++) begin
      px[c] = pixel_i[(2-c)*ChanW +: ChanW];
      l[c]  = (ElevW+3)'(signed'(levels_i[c*16 +: 16])) <<< 2;
    end
    t[0] = (ElevW+3)'(elev_i) < l[0];
    t[1] = !t[0] && ((ElevW+3)'(elev_i) < l[1]);
    t[2] = !t[0] && !t[1] && ((ElevW+3)'(elev_i) < l[2]);
    for (int c = 0; c < 3; c++) begin
      sum = {1'b0, px[c]} + TintAdd;
      tint_d[(2-c)*ChanW +: ChanW] = (t[c] && sum < ChanLimit) ? sum[ChanW-1:0] : px[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [IdxW-1:0] seg;
    logic found;
    seg = '0;
    found = 1'b0;
    for (int x = 0; x < Last; x++) begin
      if (!found && elev_i < pelev(point_i[x+1])) begin
        seg = IdxW'(x);
        found = 1'b1;
      end
    end
    e_q    <= elev_i;
    tint_q <= tint_d;
    e0_q   <= pelev(point_i[seg]);
    e1_q   <= pelev(point_i[seg + IdxW'(1)]);
    if (elev_i < pelev(point_i[0])) begin
      dir_q <= 1'b1;
      for (int c = 0; c < 3; c++) begin
        c0_q[c] <= point_i[0][(2-c)*ChanW +: ChanW];
        c1_q[c] <= point_i[0][(2-c)*ChanW +: ChanW];
      end
    end else if (!found || elev_i >= pelev(point_i[Last])) begin
      dir_q <= 1'b1;
      for (int c = 0; c < 3; c++) begin
        c0_q[c] <= point_i[Last][(2-c)*ChanW +: ChanW];
        c1_q[c] <= point_i[Last][(2-c)*ChanW +: ChanW];
      end
    end else begin
      dir_q <= pelev(point_i[seg + IdxW'(1)]) <= pelev(point_i[seg]);
      for (int c = 0; c < 3; c++) begin
        c0_q[c] <= point_i[seg][(2-c)*ChanW +: ChanW];
        c1_q[c] <= point_i[seg + IdxW'(1)][(2-c)*ChanW +: ChanW];
      end
    end
  end

  // Stage B: numerator products
  logic      vb_q;
  div_job_t  job_q;
  logic [3*ChanW-1:0] tintb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [NumW-1:0] a, b;
    a = NumW'(e1_q) - NumW'(e_q);
    b = NumW'(e_q) - NumW'(e0_q);
    tintb_q   <= tint_q;
    job_q.den <= DenW'((ElevW+2)'(e1_q) - (ElevW+2)'(e0_q));
    for (int c = 0; c < 3; c++) begin
      job_q.chan[c].direct <= dir_q;
      job_q.chan[c].color  <= c0_q[c];
      job_q.chan[c].num    <= a * NumW'(signed'({1'b0, c0_q[c]}))
                            + b * NumW'(signed'({1'b0, c1_q[c]}));
    end
  end

  assign valid_o = vb_q;
  assign job_o   = job_q;
  assign tint_o  = tintb_q;
endmodule
`default_nettype wire

### rtl/elevation_heat_map_and_flood_tint.sv
`default_nettype none
// Channel   Ports                                   Transfer
// config    cfg_we_i, cfg_idx_i, cfg_data_i          cfg_we_i high at clk edge
// pixel     start, busy, elevation_*, pixel_*         start && !busy
// result    done_o, heat_*_o, flood_*_o               done_o high, one cycle
//
// One pixel per cycle; two front stages, eleven divider stages and one
// output stage. busy is always low. The ten-stage restoring divider
// sets the latency. Reset restores all breakpoints and flood levels; the
// receiver cannot stall, so nothing ever holds.
module elevation_heat_map_and_flood_tint #(
  parameter int unsigned RAMP_POINTS = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ehm_pkg::IdxW-1:0]           cfg_idx_i,
  input  logic [ehm_pkg::RegW-1:0]           cfg_data_i,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ehm_pkg::ElevW-1:0]   elevation_qm_i,
  input  logic                               elevation_valid_i,
  input  logic [ehm_pkg::ChanW-1:0]          pixel_blue_i,
  input  logic [ehm_pkg::ChanW-1:0]          pixel_green_i,
  input  logic [ehm_pkg::ChanW-1:0]          pixel_red_i,
  output logic                               done_o,
  output logic [ehm_pkg::ChanW-1:0]          heat_blue_o,
  output logic [ehm_pkg::ChanW-1:0]          heat_green_o,
  output logic [ehm_pkg::ChanW-1:0]          heat_red_o,
  output logic [ehm_pkg::ChanW-1:0]          flood_blue_o,
  output logic [ehm_pkg::ChanW-1:0]          flood_green_o,
  output logic [ehm_pkg::ChanW-1:0]          flood_red_o
);
  import ehm_pkg::*;

  localparam int unsigned TintDelay = 12;

  logic [PointW-1:0] point_q [NumRampRegs];
  logic [LevelW-1:0] levels_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q  <= RampReset;
      levels_q <= LevelReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < IdxW'(NumRampRegs)) begin
        point_q[cfg_idx_i] <= cfg_data_i[PointW-1:0];
      end else if (cfg_idx_i == IdxFlood) begin
        levels_q <= cfg_data_i[LevelW-1:0];
      end
    end
  end

  assign busy = 1'b0;

  logic signed [ElevW-1:0] elev;
  assign elev = elevation_valid_i ? elevation_qm_i : InvalidElev;

  logic               f_valid;
  div_job_t           f_job;
  logic [3*ChanW-1:0] f_tint;

  ehm_front #(.RampPoints(RAMP_POINTS)) u_front (
    .clk_i, .rst_ni,
    .valid_i (start && !busy),
    .elev_i  (elev),
    .point_i (point_q),
    .levels_i(levels_q),
    .pixel_i ({pixel_blue_i, pixel_green_i, pixel_red_i}),
    .valid_o (f_valid),
    .job_o   (f_job),
    .tint_o  (f_tint)
  );

  logic               d_valid;
  logic [3*ChanW-1:0] d_color;

  ehm_divider u_div (
    .clk_i, .rst_ni,
    .valid_i(f_valid),
    .job_i  (f_job),
    .valid_o(d_valid),
    .color_o(d_color)
  );

  // Delay tint to match divider latency
  logic [3*ChanW-1:0] tint_q [TintDelay+1];
  assign tint_q[0] = f_tint;
  for (genvar i = 0; i < TintDelay; i++) begin : g_tint
    always_ff @(posedge clk_i) begin
      tint_q[i+1] <= tint_q[i];
    end
  end

  assign done_o        = d_valid;
  assign heat_blue_o   = d_color[3*ChanW-1:2*ChanW];
  assign heat_green_o  = d_color[2*ChanW-1:ChanW];
  assign heat_red_o    = d_color[ChanW-1:0];
  assign flood_blue_o  = tint_q[TintDelay][3*ChanW-1:2*ChanW];
  assign flood_green_o = tint_q[TintDelay][2*ChanW-1:ChanW];
  assign flood_red_o   = tint_q[TintDelay][ChanW-1:0];
endmodule
`default_nettype wire

### rtl/ehm_checker.sv
`default_nettype none
module ehm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);
  // Never busy: a pixel can be taken every cycle
  a_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  // Each accepted pixel must show up as done_o at the pipeline output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##14 done_o) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 14)) else $error("spurious result");
endmodule

bind elevation_heat_map_and_flood_tint ehm_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o)
);
`default_nettype wire

### dv/ehm_checker.sv
`timescale 1ns / 100ps
module ehm_scoreboard (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ehm_pkg::IdxW-1:0]         cfg_idx_i,
  input  logic [ehm_pkg::RegW-1:0]         cfg_data_i,
  input  logic                             start,
  input  logic                             busy,
  input  logic signed [ehm_pkg::ElevW-1:0] elevation_qm_i,
  input  logic                             elevation_valid_i,
  input  logic [7:0]                       pixel_blue_i,
  input  logic [7:0]                       pixel_green_i,
  input  logic [7:0]                       pixel_red_i,
  input  logic                             done_o,
  input  logic [7:0]                       heat_blue_o,
  input  logic [7:0]                       heat_green_o,
  input  logic [7:0]                       heat_red_o,
  input  logic [7:0]                       flood_blue_o,
  input  logic [7:0]                       flood_green_o,
  input  logic [7:0]                       flood_red_o,
  output int                               errors,
  output int                               pending
);
  import ehm_pkg::*;

  localparam int unsigned NPts = 6;

  typedef struct packed {
    logic [7:0] hb, hg, hr, fb, fg, fr;
  } colors_t;

  logic [PointW-1:0] ramp_q [NumRampRegs];
  logic [LevelW-1:0] levels_q;
  colors_t           expected_colors [$];

  function automatic longint pt_elev(int i);
    logic signed [ElevW-1:0] v;
    v = ramp_q[i][41:24];
    return longint'(v);
  endfunction

  function automatic longint pt_chan(int i, int c);
    return longint'(ramp_q[i][16-8*c +: 8]);
  endfunction

  // Blend one channel between breakpoints x and x+1 with floor division
  function automatic logic [7:0] blend(longint e, int x, int c);
    longint e0, e1, d, n, q;
    e0 = pt_elev(x);
    e1 = pt_elev(x + 1);
    d = e1 - e0;
    if (d <= 0) return pt_chan(x, c);
    n = (e1 - e) * pt_chan(x, c) + (e - e0) * pt_chan(x + 1, c);
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic logic [7:0] tint(logic [7:0] p, logic sel);
    if (sel && (int'(p) + 90 < 255)) return p + 8'd90;
    return p;
  endfunction

  function automatic colors_t color_pixel(logic signed [ElevW-1:0] qm, logic vld,
                                          logic [7:0] b, logic [7:0] g,
                                          logic [7:0] r);
    colors_t    o;
    longint     e, l0, l1, l2;
    logic [7:0] h [3];
    logic       tb, tg, tr;
    logic signed [15:0] lv;
    e = vld ? longint'(qm) : -40;
    for (int c = 0; c < 3; c++) begin
      if (e < pt_elev(0)) begin
        h[c] = pt_chan(0, c);
      end else if (e >= pt_elev(NPts - 1)) begin
        h[c] = pt_chan(NPts - 1, c);
      end else begin
        h[c] = pt_chan(NPts - 1, c);
        for (int x = 0; x < NPts - 1; x++) begin
          if (e < pt_elev(x + 1)) begin
            h[c] = blend(e, x, c);
            break;
          end
        end
      end
    end
    lv = levels_q[15:0];  l0 = longint'(lv) * 4;
    lv = levels_q[31:16]; l1 = longint'(lv) * 4;
    lv = levels_q[47:32]; l2 = longint'(lv) * 4;
    tb = e < l0;
    tg = !tb && e < l1;
    tr = !tb && !tg && e < l2;
    o.hb = h[0]; o.hg = h[1]; o.hr = h[2];
    o.fb = tint(b, tb); o.fg = tint(g, tg); o.fr = tint(r, tr);
    return o;
  endfunction

  // Track registers, queue predictions, compare each result
  always @(posedge clk_i or negedge rst_ni) begin
    colors_t exp_c, got;
    if (!rst_ni) begin
      for (int i = 0; i < NumRampRegs; i++) ramp_q[i] <= RampReset[i];
      levels_q <= LevelReset;
      errors <= 0;
      pending <= 0;
      expected_colors.delete();
    end else begin
      if (done_o) begin
        got = '{heat_blue_o, heat_green_o, heat_red_o,
                flood_blue_o, flood_green_o, flood_red_o};
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_c = expected_colors.pop_front();
          if (exp_c !== got) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_c, got);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy)
        expected_colors.insert(expected_colors.size(),
                               color_pixel(elevation_qm_i, elevation_valid_i,
                                           pixel_blue_i, pixel_green_i,
                                           pixel_red_i));
      pending <= expected_colors.size();
      if (cfg_we_i) begin
        if (cfg_idx_i < NumRampRegs) ramp_q[cfg_idx_i] <= cfg_data_i[PointW-1:0];
        else if (cfg_idx_i == IdxFlood) levels_q <= cfg_data_i;
      end
    end
  end
endmodule

### dv/tb_elevation_heat_map_and_flood_tint.sv
`timescale 1ns / 100ps
module tb_elevation_heat_map_and_flood_tint;
  import ehm_pkg::*;

  localparam int Limit = 200000;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_data_i = '0;
  logic start = 1'b0, busy, done_o, elevation_valid_i = 1'b0;
  logic signed [ElevW-1:0] elevation_qm_i = '0;
  logic [7:0] pixel_blue_i = '0, pixel_green_i = '0, pixel_red_i = '0;
  logic [7:0] heat_blue_o, heat_green_o, heat_red_o;
  logic [7:0] flood_blue_o, flood_green_o, flood_red_o;
  int errors, pending, cycles;
  int idle_pct;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  elevation_heat_map_and_flood_tint uut (.*);

  ehm_scoreboard u_checker (.*);

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("simulation failed");
      $finish;
    end
  end
  initial cycles = 0;

  task automatic write_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drive one pixel until it transfers, idling at random first; start stays
  // high afterwards so the next pixel can follow in the very next cycle
  task automatic send_pixel(logic signed [ElevW-1:0] qm, logic vld,
                            logic [7:0] b, logic [7:0] g, logic [7:0] r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    elevation_qm_i <= qm; elevation_valid_i <= vld;
    pixel_blue_i <= b; pixel_green_i <= g; pixel_red_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [RegW-1:0] pack_point(int e, int b, int g, int r);
    logic [17:0] ev;
    ev = e;
    return {6'd0, ev, b[7:0], g[7:0], r[7:0]};
  endfunction

  function automatic logic signed [ElevW-1:0] rand_elev();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return $signed($urandom_range(1300)) - 200;
    return $urandom;
  endfunction

  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++) begin
      send_pixel(rand_elev(), $urandom_range(7) != 0,
                 $urandom, $urandom, $urandom);
      // Back-to-back stretch with no idling now and then
      if ($urandom_range(99) == 0) begin
        int keep;
        keep = idle_pct;
        idle_pct = 0;
        for (int k = 0; k < 20; k++)
          send_pixel(rand_elev(), 1'b1, $urandom, $urandom, $urandom);
        idle_pct = keep;
      end
    end
  endtask

  initial begin
    int pts [6];
    idle_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset ramp, breakpoints, extremes, invalid, saturating tint
    foreach (pts[i]) pts[i] = 0;
    send_pixel(-18'sd131072, 1'b1, 8'd0, 8'd0, 8'd0);
    send_pixel(18'sd131071, 1'b1, 8'd255, 8'd255, 8'd255);
    send_pixel(18'sd123, 1'b0, 8'd164, 8'd165, 8'd164);
    send_pixel(-18'sd4, 1'b1, 8'd165, 8'd164, 8'd0);
    send_pixel(-18'sd5, 1'b1, 8'd1, 8'd2, 8'd3);
    send_pixel(18'sd1, 1'b1, 8'd10, 8'd10, 8'd10);
    send_pixel(18'sd40, 1'b1, 8'd10, 8'd10, 8'd10);
    send_pixel(18'sd80, 1'b1, 8'd10, 8'd164, 8'd10);
    send_pixel(18'sd199, 1'b1, 8'd10, 8'd165, 8'd10);
    send_pixel(18'sd200, 1'b1, 8'd10, 8'd10, 8'd164);
    send_pixel(18'sd399, 1'b1, 8'd10, 8'd10, 8'd10);
    send_pixel(18'sd400, 1'b1, 8'd10, 8'd10, 8'd10);
    send_pixel(18'sd799, 1'b1, 8'd10, 8'd10, 8'd10);
    send_pixel(18'sd800, 1'b1, 8'd10, 8'd10, 8'd10);
    drain();

    // Extreme ramp, descending segments and extreme levels
    write_reg(0, pack_point(-131072, 255, 0, 255));
    write_reg(1, pack_point(-100, 0, 255, 0));
    write_reg(2, pack_point(-200, 255, 255, 255));
    write_reg(3, pack_point(0, 0, 0, 0));
    write_reg(4, pack_point(0, 128, 64, 32));
    write_reg(5, pack_point(131071, 255, 255, 255));
    write_reg(IdxFlood, {16'h7fff, 16'h0000, 16'h8000});
    write_reg(7, '1);
    send_pixel(-18'sd131072, 1'b1, 8'd1, 8'd1, 8'd1);
    send_pixel(-18'sd150, 1'b1, 8'd1, 8'd1, 8'd1);
    send_pixel(-18'sd50, 1'b1, 8'd1, 8'd1, 8'd1);
    send_pixel(18'sd5, 1'b1, 8'd1, 8'd1, 8'd1);
    send_pixel(18'sd131071, 1'b1, 8'd1, 8'd1, 8'd1);
    send_pixel(18'sd0, 1'b0, 8'd1, 8'd1, 8'd1);
    drain();

    // Random phases, new ramp each time, all bits random in the last phase
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 18 : (ph == 1) ? 51 : 0;
      for (int i = 0; i < 6; i++) begin
        logic [RegW-1:0] v;
        if (ph == 2) v = {$urandom, $urandom};
        else v = pack_point(-150 + i * ($urandom_range(300) + 1)
                            + $urandom_range(20), $urandom, $urandom, $urandom);
        write_reg(i, v);
      end
      write_reg(IdxFlood, (ph == 2) ? {$urandom, $urandom} :
                {16'($urandom_range(300)), 16'($urandom_range(120)),
                 16'($signed($urandom_range(60)) - 20)});
      random_pixels(380);
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
rtl/ehm_pkg.sv
rtl/ehm_divider.sv
rtl/ehm_front.sv
rtl/elevation_heat_map_and_flood_tint.sv
rtl/ehm_checker.sv
dv/ehm_checker.sv
dv/tb_elevation_heat_map_and_flood_tint.sv
